FILE: hw/rtl/dual_tag_pose_aligner_unit_assert.svh
// Assertion macros for the dual tag pose aligner.
// Included by the top level; depends on nothing else.
`ifndef DUAL_TAG_POSE_ALIGNER_UNIT_ASSERT_SVH
`define DUAL_TAG_POSE_ALIGNER_UNIT_ASSERT_SVH

// Same-cycle implication, quiet during reset
`define DTPA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dtpa check failed");

// Next-cycle implication, quiet during reset
`define DTPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dtpa check failed");

`endif

FILE: hw/rtl/dtpa_pkg.sv
// Shared types, codes and the arctangent table of the pose aligner.
// No dependencies.
package dtpa_pkg;

   // Operation codes of an input word
   localparam logic [1:0] OP_SAMPLE_A = 2'd0;
   localparam logic [1:0] OP_SAMPLE_B = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;

   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_W     = 36;

   typedef struct packed {
      logic [1:0]         operation;
      logic [31:0]        sample_time;
      logic signed [31:0] sample_x;
      logic signed [31:0] sample_y;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] mid_x;
      logic signed [31:0] mid_y;
      logic signed [15:0] heading;
      logic [7:0]         dropped_count;
   } rsp_word_type;

   // One queued sample
   typedef struct packed {
      logic [31:0]        stamp;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } entry_type;

   typedef enum logic [4:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_PUSH,
      CMD_LATCH_LEAD,
      CMD_RD_NEXT,
      CMD_POP_LEAD,
      CMD_KEEP_PAIR,
      CMD_KEEP_L0,
      CMD_MD_LOAD,
      CMD_MUL_STEP,
      CMD_DIV_STEP,
      CMD_MD_DONE,
      CMD_COR_INIT,
      CMD_COR_STEP,
      CMD_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       axis_y;
      logic [4:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       known;
      logic       both_ready;
      logic       lead_ok;
      logic       stale;
      logic       lead_multi;
      logic       lead_gt1;
      logic       out_free;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TICK,
      ST_RD_HEADS,
      ST_LATCH,
      ST_CHKCNT,
      ST_RD_NEXT,
      ST_CHECK,
      ST_KEEP_L0,
      ST_MD_LOAD,
      ST_MUL,
      ST_DIV,
      ST_MD_DONE,
      ST_COR_INIT,
      ST_COR,
      ST_EMIT
   } ctrl_state_type;

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/dtpa_ctrl.sv
// Sequencer of the pose aligner: walks each word through push, stale drop,
// interpolation, heading and output. Depends on dtpa_pkg.
module dtpa_ctrl import dtpa_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          idle,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

   ctrl_state_type state_ff, state_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic           axis_ff, axis_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      axis_in    = axis_ff;
      cmd.op     = CMD_IDLE;
      cmd.axis_y = axis_ff;
      cmd.step   = cnt_ff[4:0];
      idle       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (req_valid) begin
               cmd.op   = CMD_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.operation)
               OP_SAMPLE_A, OP_SAMPLE_B: begin
                  cmd.op   = CMD_PUSH;
                  state_in = ST_IDLE;
               end
               OP_TICK: state_in = ST_TICK;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_TICK: begin
            if (status.known) state_in = ST_CHKCNT;
            else if (status.both_ready) state_in = ST_RD_HEADS;
            else state_in = ST_IDLE;
         end
         // head reads are in flight
         ST_RD_HEADS: state_in = ST_LATCH;
         ST_LATCH: begin
            cmd.op   = CMD_LATCH_LEAD;
            state_in = ST_CHKCNT;
         end
         ST_CHKCNT: state_in = status.lead_ok ? ST_RD_NEXT : ST_IDLE;
         ST_RD_NEXT: begin
            cmd.op   = CMD_RD_NEXT;
            state_in = ST_CHECK;
         end
         // drop a stale leading head or keep the pair
         ST_CHECK: begin
            if (status.stale) begin
               cmd.op   = CMD_POP_LEAD;
               state_in = status.lead_multi ? ST_RD_NEXT : ST_IDLE;
            end else begin
               cmd.op   = CMD_KEEP_PAIR;
               state_in = ST_KEEP_L0;
            end
         end
         ST_KEEP_L0: begin
            cmd.op   = CMD_KEEP_L0;
            axis_in  = 1'b0;
            state_in = ST_MD_LOAD;
         end
         ST_MD_LOAD: begin
            cmd.op   = CMD_MD_LOAD;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op = CMD_MUL_STEP;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd31) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = CMD_DIV_STEP;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) state_in = ST_MD_DONE;
         end
         ST_MD_DONE: begin
            cmd.op = CMD_MD_DONE;
            if (axis_ff) begin
               state_in = ST_COR_INIT;
            end else begin
               axis_in  = 1'b1;
               state_in = ST_MD_LOAD;
            end
         end
         ST_COR_INIT: begin
            cmd.op   = CMD_COR_INIT;
            cnt_in   = '0;
            state_in = ST_COR;
         end
         ST_COR: begin
            cmd.op = CMD_COR_STEP;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(NSTEP - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = CMD_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/dtpa_datapath.sv
// Datapath of the pose aligner: sample queues, shift-add multiplier,
// restoring divider, CORDIC and output register. Depends on dtpa_pkg.
module dtpa_datapath import dtpa_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_word,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_word_type  rsp_word
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = AW + 1;

   // Queue memories and their pointers
   entry_type    mem_a_ff [QUEUE_DEPTH];
   entry_type    mem_b_ff [QUEUE_DEPTH];
   entry_type    rd_a_ff, rd_b_ff;
   logic [AW-1:0] a_head_ff, b_head_ff;
   logic [CW-1:0] a_cnt_ff, b_cnt_ff;
   logic          known_ff, lead_b_ff;
   logic [7:0]    tally_ff;
   req_word_type  req_ff;

   // Work registers
   entry_type          l0_ff, l1_ff, o0_ff;
   logic signed [31:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [31:0]        up_ff, down_ff;
   logic [32:0]        mag_ff;
   logic               neg_ff;
   logic signed [31:0] p0_ff;
   logic [64:0]        prod_ff;
   logic [31:0]        rem_ff;
   logic signed [CORDIC_W-1:0] cx_ff, cy_ff;
   logic [31:0]        z_ff;
   logic               zero_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_ff;

   function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
      return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] tail_of(input logic [AW-1:0] h, input logic [CW-1:0] c);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(c);
      if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
      return s[AW-1:0];
   endfunction

   logic [AW-1:0] ra_a, ra_b;
   logic          a_full, b_full;
   logic [CW-1:0] lead_cnt, other_cnt;
   entry_type     lead_rd, other_rd;

   assign a_full    = (a_cnt_ff == CW'(QUEUE_DEPTH));
   assign b_full    = (b_cnt_ff == CW'(QUEUE_DEPTH));
   assign lead_cnt  = lead_b_ff ? b_cnt_ff : a_cnt_ff;
   assign other_cnt = lead_b_ff ? a_cnt_ff : b_cnt_ff;
   assign lead_rd   = lead_b_ff ? rd_b_ff : rd_a_ff;
   assign other_rd  = lead_b_ff ? rd_a_ff : rd_b_ff;

   // Read addresses: heads, or the second leading entry during the stale walk
   always_comb begin
      ra_a = a_head_ff;
      ra_b = b_head_ff;
      if (cmd.op == CMD_RD_NEXT) begin
         if (lead_b_ff) ra_b = wrap_next(b_head_ff);
         else ra_a = wrap_next(a_head_ff);
      end
   end

   // Memory ports
   always_ff @(posedge clock) begin
      rd_a_ff <= mem_a_ff[ra_a];
      rd_b_ff <= mem_b_ff[ra_b];
      if (cmd.op == CMD_PUSH && req_ff.operation == OP_SAMPLE_A && !a_full)
         mem_a_ff[tail_of(a_head_ff, a_cnt_ff)] <= {req_ff.sample_time, req_ff.sample_x,
                                                    req_ff.sample_y};
      if (cmd.op == CMD_PUSH && req_ff.operation == OP_SAMPLE_B && !b_full)
         mem_b_ff[tail_of(b_head_ff, b_cnt_ff)] <= {req_ff.sample_time, req_ff.sample_x,
                                                    req_ff.sample_y};
   end

   // Status to the sequencer
   always_comb begin
      status.operation  = req_ff.operation;
      status.known      = known_ff;
      status.both_ready = (a_cnt_ff != '0) && (b_cnt_ff != '0);
      status.lead_ok    = (lead_cnt >= CW'(2)) && (other_cnt != '0);
      status.stale      = lead_rd.stamp < other_rd.stamp;
      status.lead_multi = lead_cnt > CW'(2);
      status.lead_gt1   = lead_cnt > CW'(1);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Interpolation operands
   logic signed [32:0] diff;
   entry_type          l0_sel;
   logic signed [31:0] p0_sel, p1_sel;
   always_comb begin
      l0_sel = l0_ff;
      p0_sel = cmd.axis_y ? l0_ff.pos_y : l0_ff.pos_x;
      p1_sel = cmd.axis_y ? l1_ff.pos_y : l1_ff.pos_x;
      diff   = 33'(p1_sel) - 33'(p0_sel);
   end

   // Divider step
   logic [32:0] rem_sh, rem_sub;
   logic        ge;
   assign rem_sh  = {rem_ff, prod_ff[64]};
   assign ge      = rem_sh >= {1'b0, down_ff};
   assign rem_sub = rem_sh - {1'b0, down_ff};

   // Quotient saturation, offset and clamp
   logic [32:0]        qs;
   logic signed [33:0] sum34;
   logic signed [31:0] interp;
   always_comb begin
      if ((|prod_ff[64:33]) || (prod_ff[32] && (|prod_ff[31:0]))) qs = 33'h1_0000_0000;
      else qs = prod_ff[32:0];
      sum34 = neg_ff ? 34'(p0_ff) - $signed({1'b0, qs}) : 34'(p0_ff) + $signed({1'b0, qs});
      if (sum34[33:31] == 3'b000 || sum34[33:31] == 3'b111) interp = sum34[31:0];
      else interp = sum34[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      if (down_ff == '0) interp = p0_ff;
   end

   // CORDIC operands
   logic signed [32:0] dx, dy;
   logic signed [CORDIC_W-1:0] xs, ys;
   logic [31:0] zr;
   logic signed [32:0] sx, sy;
   assign dx = 33'(bx_ff) - 33'(ax_ff);
   assign dy = 33'(by_ff) - 33'(ay_ff);
   assign xs = cx_ff >>> cmd.step;
   assign ys = cy_ff >>> cmd.step;
   assign zr = z_ff + 32'h0000_8000;
   assign sx = (33'(ax_ff) + 33'(bx_ff)) >>> 1;
   assign sy = (33'(ay_ff) + 33'(by_ff)) >>> 1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_head_ff    <= '0;
         b_head_ff    <= '0;
         a_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
         known_ff     <= 1'b0;
         lead_b_ff    <= 1'b0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register: filled on emit, emptied when taken
         if (cmd.op == CMD_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            CMD_PUSH: begin
               if (req_ff.operation == OP_SAMPLE_A) begin
                  if (a_full) tally_ff <= (tally_ff == 8'hff) ? tally_ff : tally_ff + 8'd1;
                  else a_cnt_ff <= a_cnt_ff + CW'(1);
               end else begin
                  if (b_full) tally_ff <= (tally_ff == 8'hff) ? tally_ff : tally_ff + 8'd1;
                  else b_cnt_ff <= b_cnt_ff + CW'(1);
               end
            end
            CMD_LATCH_LEAD: begin
               known_ff  <= 1'b1;
               lead_b_ff <= !(rd_a_ff.stamp < rd_b_ff.stamp);
            end
            CMD_POP_LEAD: begin
               if (lead_b_ff) begin
                  b_head_ff <= wrap_next(b_head_ff);
                  b_cnt_ff  <= b_cnt_ff - CW'(1);
               end else begin
                  a_head_ff <= wrap_next(a_head_ff);
                  a_cnt_ff  <= a_cnt_ff - CW'(1);
               end
            end
            CMD_EMIT: begin
               a_head_ff    <= wrap_next(a_head_ff);
               a_cnt_ff     <= a_cnt_ff - CW'(1);
               b_head_ff    <= wrap_next(b_head_ff);
               b_cnt_ff     <= b_cnt_ff - CW'(1);
            end
            default: ;
         endcase
      end
   end

   // Work registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_LOAD: req_ff <= req_word;
         CMD_KEEP_PAIR: begin
            l1_ff <= lead_rd;
            o0_ff <= other_rd;
            if (lead_b_ff) begin
               ax_ff <= other_rd.pos_x;
               ay_ff <= other_rd.pos_y;
            end else begin
               bx_ff <= other_rd.pos_x;
               by_ff <= other_rd.pos_y;
            end
         end
         CMD_KEEP_L0: l0_ff <= lead_rd;
         CMD_MD_LOAD: begin
            up_ff   <= o0_ff.stamp - l0_sel.stamp;
            down_ff <= l1_ff.stamp - l0_sel.stamp;
            p0_ff   <= p0_sel;
            neg_ff  <= diff[32];
            mag_ff  <= diff[32] ? 33'(-diff) : 33'(diff);
            prod_ff <= '0;
            rem_ff  <= '0;
         end
         CMD_MUL_STEP: begin
            prod_ff <= {prod_ff[63:0], 1'b0} + (up_ff[31] ? 65'(mag_ff) : 65'd0);
            up_ff   <= {up_ff[30:0], 1'b0};
         end
         CMD_DIV_STEP: begin
            rem_ff  <= ge ? rem_sub[31:0] : rem_sh[31:0];
            prod_ff <= {prod_ff[63:0], ge};
         end
         CMD_MD_DONE: begin
            if (lead_b_ff) begin
               if (cmd.axis_y) by_ff <= interp;
               else bx_ff <= interp;
            end else begin
               if (cmd.axis_y) ay_ff <= interp;
               else ax_ff <= interp;
            end
         end
         CMD_COR_INIT: begin
            zero_ff <= (dx == '0) && (dy == '0);
            if (dx[32]) begin
               cx_ff <= -CORDIC_W'(dx);
               cy_ff <= -CORDIC_W'(dy);
               z_ff  <= 32'h8000_0000;
            end else begin
               cx_ff <= CORDIC_W'(dx);
               cy_ff <= CORDIC_W'(dy);
               z_ff  <= '0;
            end
         end
         CMD_COR_STEP: begin
            if (cy_ff > 0) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               z_ff  <= z_ff + atan_entry(cmd.step);
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               z_ff  <= z_ff - atan_entry(cmd.step);
            end
         end
         CMD_EMIT: begin
            rsp_ff.mid_x         <= sx[31:0];
            rsp_ff.mid_y         <= sy[31:0];
            rsp_ff.heading       <= zero_ff ? 16'sd0 : zr[31:16];
            rsp_ff.dropped_count <= tally_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

FILE: hw/rtl/dual_tag_pose_aligner_unit.sv
// Dual tag pose aligner: one word in flight, results through an output register.
// Sample word: pushed to its queue. Tick that pairs: latches the leading tag when not yet
// known, drops stale leading heads, then two passes of 32 multiply and 65 divide steps,
// then CORDIC, and any wait for the output register; a tick that cannot pair ends with no
// result after its stale walk.
// Reset clears pointers, counts, leading choice and drop tally; queues need none.
module dual_tag_pose_aligner_unit import dtpa_pkg::*; #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   `include "dual_tag_pose_aligner_unit_assert.svh"

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          idle;

   // No word is taken while reset is held
   assign req_stall = !idle || reset;

   dtpa_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .idle      (idle),
      .status    (status),
      .cmd       (cmd)
   );

   dtpa_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Checks
   `DTPA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `DTPA_ASSERT_NOW(a_emit_into_free, cmd.op == CMD_EMIT, !(rsp_valid && rsp_stall))
   `DTPA_ASSERT_NOW(a_pop_keeps_one, cmd.op == CMD_POP_LEAD, status.lead_gt1)
   `DTPA_ASSERT_NEXT(a_emit_shows, cmd.op == CMD_EMIT, rsp_valid)

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for dual_tag_pose_aligner_unit: tag A/B samples and ticks,
// results compared field by field against an in-bench pose predictor.
// Depends on dtpa_pkg and the unit's RTL only.
module tb_top;
   import dtpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH    = 16;
   localparam int STEPS    = 16;
   localparam int WDOG_MAX = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   dual_tag_pose_aligner_unit #(.QUEUE_DEPTH(DEPTH), .CORDIC_STEPS(STEPS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state
   logic [31:0]        a_t[DEPTH], b_t[DEPTH];
   logic signed [31:0] a_x[DEPTH], a_y[DEPTH], b_x[DEPTH], b_y[DEPTH];
   int                 a_head, a_cnt, b_head, b_cnt;
   bit                 lead_known, lead_b;
   int                 drops;

   rsp_word_type pose_q[$];
   int           errors = 0;
   int           send_idle = 0, recv_idle = 0;
   bit           hold_off = 0;
   int           quiet = 0;

   function automatic longint fshift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic logic signed [31:0] interp(logic [31:0] t0, logic [31:0] t1,
         logic [31:0] tq, logic signed [31:0] p0, logic signed [31:0] p1);
      logic [31:0] up, down;
      longint      diff, r;
      logic [63:0] mag, q;
      up   = tq - t0;
      down = t1 - t0;
      if (down == 0) return p0;
      diff = longint'(p1) - longint'(p0);
      mag  = (diff < 0) ? -diff : diff;
      q    = (64'(up) * mag) / 64'(down);
      if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
      r = (diff < 0) ? longint'(p0) - longint'(q) : longint'(p0) + longint'(q);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   function automatic logic [15:0] bearing(longint dx, longint dy);
      logic [31:0] z;
      longint      x, y, xs, ys;
      logic [31:0] atan_k[24];
      z = 0;
      x = dx;
      y = dy;
      atan_k = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
         z = 32'h8000_0000;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         xs = fshift(x, i);
         ys = fshift(y, i);
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_k[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_k[i];
         end
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   // Advance the predictor by one accepted word
   task automatic predict_pose(input req_word_type w);
      logic signed [31:0] ax, ay, bx, by;
      longint             sx, sy;
      int                 s0, s1;
      rsp_word_type       r;
      if (w.operation == OP_SAMPLE_A || w.operation == OP_SAMPLE_B) begin
         if (w.operation == OP_SAMPLE_A ? a_cnt >= DEPTH : b_cnt >= DEPTH) begin
            if (drops < 255) drops++;
         end else if (w.operation == OP_SAMPLE_A) begin
            s0 = (a_head + a_cnt) % DEPTH;
            a_t[s0] = w.sample_time; a_x[s0] = w.sample_x; a_y[s0] = w.sample_y;
            a_cnt++;
         end else begin
            s0 = (b_head + b_cnt) % DEPTH;
            b_t[s0] = w.sample_time; b_x[s0] = w.sample_x; b_y[s0] = w.sample_y;
            b_cnt++;
         end
         return;
      end
      if (w.operation != OP_TICK) return;
      if (!lead_known && a_cnt > 0 && b_cnt > 0) begin
         lead_known = 1;
         lead_b = !(a_t[a_head] < b_t[b_head]);
      end
      if (!lead_known) return;
      if (!lead_b) begin
         if (a_cnt < 2 || b_cnt < 1) return;
         while (a_cnt > 1 && a_t[(a_head + 1) % DEPTH] < b_t[b_head]) begin
            a_head = (a_head + 1) % DEPTH; a_cnt--;
         end
         if (a_cnt < 2) return;
         s0 = a_head; s1 = (a_head + 1) % DEPTH;
         ax = interp(a_t[s0], a_t[s1], b_t[b_head], a_x[s0], a_x[s1]);
         ay = interp(a_t[s0], a_t[s1], b_t[b_head], a_y[s0], a_y[s1]);
         bx = b_x[b_head]; by = b_y[b_head];
      end else begin
         if (b_cnt < 2 || a_cnt < 1) return;
         while (b_cnt > 1 && b_t[(b_head + 1) % DEPTH] < a_t[a_head]) begin
            b_head = (b_head + 1) % DEPTH; b_cnt--;
         end
         if (b_cnt < 2) return;
         s0 = b_head; s1 = (b_head + 1) % DEPTH;
         bx = interp(b_t[s0], b_t[s1], a_t[a_head], b_x[s0], b_x[s1]);
         by = interp(b_t[s0], b_t[s1], a_t[a_head], b_y[s0], b_y[s1]);
         ax = a_x[a_head]; ay = a_y[a_head];
      end
      a_head = (a_head + 1) % DEPTH; a_cnt--;
      b_head = (b_head + 1) % DEPTH; b_cnt--;
      sx = fshift(longint'(ax) + longint'(bx), 1);
      sy = fshift(longint'(ay) + longint'(by), 1);
      r.mid_x = sx[31:0];
      r.mid_y = sy[31:0];
      r.heading = bearing(longint'(bx) - longint'(ax), longint'(by) - longint'(ay));
      r.dropped_count = drops[7:0];
      pose_q = {pose_q, r};
   endtask

   // Drive one word, honouring the sender's idle rate; valid stays up on return
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pose(w);
   endtask

   function automatic req_word_type mk(logic [1:0] op, logic [31:0] t,
         logic [31:0] x, logic [31:0] y);
      req_word_type w;
      w.operation = op; w.sample_time = t; w.sample_x = x; w.sample_y = y;
      return w;
   endfunction

   // Receiver stall and long hold-off
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_off || ($urandom_range(99) < recv_idle);
   end

   // Result checker
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_q.size() == 0) begin
            $display("%0t unexpected word %h", $time, rsp_word);
            errors++;
         end else begin
            e = pose_q.pop_front();
            if (rsp_word.mid_x !== e.mid_x)
               $display("%0t mid_x exp %h got %h", $time, e.mid_x, rsp_word.mid_x);
            if (rsp_word.mid_y !== e.mid_y)
               $display("%0t mid_y exp %h got %h", $time, e.mid_y, rsp_word.mid_y);
            if (rsp_word.heading !== e.heading)
               $display("%0t heading exp %h got %h", $time, e.heading, rsp_word.heading);
            if (rsp_word.dropped_count !== e.dropped_count)
               $display("%0t dropped exp %h got %h", $time, e.dropped_count,
                        rsp_word.dropped_count);
            if (rsp_word !== e) errors++;
         end
      end
   end

   // Watchdog on cycles without any accepted word or taken result
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WDOG_MAX) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Directed rows: samples, ticks, extremes, unused op, overflow
   req_word_type stim_rows[$];
   rsp_word_type want;

   task automatic send_pair(input logic [31:0] t, input bit a_lead);
      logic [31:0] tb;
      tb = t + $urandom_range(1, 50);
      if (a_lead) begin
         send_word(mk(OP_SAMPLE_A, t, $urandom, $urandom));
         send_word(mk(OP_SAMPLE_B, tb, $urandom, $urandom));
      end else begin
         send_word(mk(OP_SAMPLE_B, t, $urandom, $urandom));
         send_word(mk(OP_SAMPLE_A, tb, $urandom, $urandom));
      end
   endtask

   initial begin
      int          n, wait_cnt;
      logic [31:0] clock_t;
      logic [1:0]  op;
      a_head = 0; a_cnt = 0; b_head = 0; b_cnt = 0;
      lead_known = 0; lead_b = 0; drops = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Tick on empty queues gives nothing; A leads from time zero
      stim_rows = '{
         mk(OP_TICK, '1, '1, '1),
         mk(2'd3, 32'h1234, 32'h1, 32'h1),
         mk(OP_SAMPLE_A, 32'd0, 32'h8000_0000, 32'h7fff_ffff),
         mk(OP_SAMPLE_B, 32'd100, 32'h7fff_ffff, 32'h8000_0000),
         mk(OP_TICK, 0, 0, 0),
         mk(OP_SAMPLE_A, 32'd200, 32'h7fff_ffff, 32'h8000_0000),
         mk(OP_TICK, 0, 0, 0),
         mk(OP_SAMPLE_B, 32'd200, 32'h0001_0000, 32'h0001_0000),
         mk(OP_SAMPLE_A, 32'd200, 32'h0005_0000, 32'h0005_0000),
         mk(OP_SAMPLE_A, 32'd200, 32'h0001_0000, 32'h0001_0000),
         mk(OP_TICK, 0, 0, 0),
         mk(OP_SAMPLE_B, 32'hffff_ffff, 32'h0, 32'h0),
         mk(OP_SAMPLE_A, 32'hffff_ffff, 32'h0, 32'h0),
         mk(OP_TICK, 0, 0, 0),
         mk(OP_TICK, 0, 0, 0)
      };
      foreach (stim_rows[i]) send_word(stim_rows[i]);
      // Fill queue A past its depth to count drops
      for (int i = 0; i < DEPTH + 3; i++)
         send_word(mk(OP_SAMPLE_A, 32'h1000 + i * 10, $urandom, $urandom));
      req_valid <= 1'b0;
      // After the drain, one B sample and a tick pair with the queued A samples
      wait (pose_q.size() == 0);
      // Drop count after overflow must show four (one sample was still queued)
      send_word(mk(OP_SAMPLE_B, 32'd5, 32'h0, 32'h0));
      send_word(mk(OP_TICK, 0, 0, 0));
      want = pose_q[$];
      if (pose_q.size() != 0 && want.dropped_count != 8'd4) begin
         $display("%0t dropped exp %h got %h", $time, 8'd4, want.dropped_count);
         errors++;
      end

      // Random phases: mostly well-formed interleaved pairs, some noise
      clock_t = 32'h2000;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 30 : (ph == 1) ? 80 : 0;
         recv_idle = (ph == 0) ? 80 : (ph == 1) ? 30 : 0;
         for (int k = 0; k < 120; k++) begin
            n = $urandom_range(99);
            if (n < 70) begin
               send_pair(clock_t, 1'($urandom_range(1)));
               clock_t = clock_t + $urandom_range(1, 300);
               send_word(mk(OP_TICK, $urandom, $urandom, $urandom));
            end else if (n < 90) begin
               op = 2'($urandom_range(3));
               send_word(mk(op, $urandom, $urandom, $urandom));
            end else begin
               clock_t = $urandom;
               send_word(mk(OP_TICK, 0, 0, 0));
            end
         end
         // Long receiver hold-off while words keep coming
         if (ph == 1) begin
            fork
               begin
                  hold_off = 1;
                  wait_cnt = 0;
                  while (wait_cnt < 3000) begin
                     @(posedge clock);
                     wait_cnt++;
                  end
                  hold_off = 0;
               end
               begin
                  for (int k = 0; k < 12; k++) begin
                     send_pair(clock_t, 1'b1);
                     clock_t = clock_t + 40;
                     send_word(mk(OP_TICK, 0, 0, 0));
                  end
                  req_valid <= 1'b0;
               end
            join
         end
      end
      req_valid <= 1'b0;
      recv_idle = 0;
      wait (pose_q.size() == 0);
      repeat (600) @(posedge clock);
      if (errors == 0 && pose_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dtpa_pkg.sv
hw/rtl/dtpa_ctrl.sv
hw/rtl/dtpa_datapath.sv
hw/rtl/dual_tag_pose_aligner_unit.sv
sim/tb_top.sv
